// ===== design/olst_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olst_pkg: shared definitions for the ordered list store
// Request modes, result status codes, sequencer states and the control
// bundle that the top level sends to every cell of the chain.
// ----------------------------------------------------------------------------
package olst_pkg;

    localparam int DEF_CAPACITY  = 16;
    localparam int DEF_WORD_BITS = 32;

    // Fixed widths of the channel fields.
    localparam int MODE_W  = 3;
    localparam int XWORD_W = 32;
    localparam int POS_W   = 4;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 5;

    localparam logic [MODE_W-1:0] MODE_APPEND = 3'd0;
    localparam logic [MODE_W-1:0] MODE_POP    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_DROP   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 3'd3;
    localparam logic [MODE_W-1:0] MODE_SEARCH = 3'd4;
    localparam logic [MODE_W-1:0] MODE_READ   = 3'd5;

    localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
    localparam logic [STAT_W-1:0] STAT_MISS = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_FIND = 3'b100
    } olst_state_t;

    typedef struct packed {
        logic shift;    // take the neighbour's word
        logic load;     // take the incoming word
        logic compare;  // register the comparison with the search word
    } olst_cell_ctrl_t;

endpackage

// ===== design/ordered_list_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_list_store: bounded ordered list with indexed remove
// A chain of word cells with a compare in every cell. Append, pop, drop,
// remove at a position, search and read, one result beat per request.
// ----------------------------------------------------------------------------
//  channel | direction | ports
//  --------+-----------+----------------------------------------------------
//  request | in        | s_valid s_ready s_mode s_word_in s_position
//  result  | out       | m_valid m_ready m_status m_word_out m_found_position
//          |           | m_entry_count
//
//  A request passes through accept, execute in the cell chain (shift, load
//  and the registered compare), then the first-match encoder feeding the
//  result register. The next request is accepted once the sequencer is idle,
//  while the result beat may still wait for m_ready. Reset empties the list at
//  once; cell contents are not cleared. A stalled result holds the sequencer in
//  its final step only when the result register is still occupied.
// ----------------------------------------------------------------------------
module ordered_list_store
    import olst_pkg::*;
#(
    parameter int CAPACITY  = DEF_CAPACITY,
    parameter int WORD_BITS = DEF_WORD_BITS
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [MODE_W-1:0]  s_mode,
    input  logic [XWORD_W-1:0] s_word_in,
    input  logic [POS_W-1:0]   s_position,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [STAT_W-1:0]  m_status,
    output logic [XWORD_W-1:0] m_word_out,
    output logic [POS_W-1:0]   m_found_position,
    output logic [COUNT_W-1:0] m_entry_count
);

    localparam int CW       = $clog2(CAPACITY + 1);
    localparam int IW       = $clog2(CAPACITY);
    localparam int CMPW     = (CW > POS_W) ? CW : POS_W;
    localparam int RD_CELLS = (CAPACITY < (1 << POS_W)) ? CAPACITY : (1 << POS_W);

    olst_state_t state_reg, state_next;

    logic [MODE_W-1:0]    req_mode_reg;
    logic [WORD_BITS-1:0] req_word_reg;
    logic [POS_W-1:0]     req_pos_reg;
    logic [CW-1:0]        held_count_reg, held_count_next;

    logic [STAT_W-1:0]    pend_status_reg, pend_status_next;
    logic [XWORD_W-1:0]   pend_word_reg, pend_word_next;

    logic                 m_valid_reg, m_valid_next;
    logic [STAT_W-1:0]    m_status_reg, m_status_next;
    logic [XWORD_W-1:0]   m_word_reg, m_word_next;
    logic [POS_W-1:0]     m_fpos_reg, m_fpos_next;
    logic [COUNT_W-1:0]   m_count_reg, m_count_next;

    logic [WORD_BITS-1:0] cell_word [CAPACITY];
    logic [CAPACITY-1:0]  cell_match;
    logic [CAPACITY-1:0]  hit_vec;
    olst_cell_ctrl_t      cell_ctrl [CAPACITY];

    logic                 exec;
    logic                 nonempty;
    logic                 full;
    logic                 pos_ok;
    logic                 do_append;
    logic                 do_remove;
    logic [POS_W-1:0]     rm_pos;
    logic [WORD_BITS-1:0] rd_word;
    logic                 hit_found;
    logic [IW-1:0]        hit_index;
    logic                 out_free;

    assign exec     = (state_reg == S_EXEC);
    assign nonempty = (held_count_reg != '0);
    assign full     = (held_count_reg == CW'(CAPACITY));
    assign pos_ok   = (CMPW'(req_pos_reg) < CMPW'(held_count_reg));
    assign do_append = exec && (req_mode_reg == MODE_APPEND) && !full;
    assign do_remove = exec && (((req_mode_reg == MODE_POP) && nonempty) ||
                                ((req_mode_reg == MODE_REMOVE) && pos_ok));
    assign rm_pos   = (req_mode_reg == MODE_POP) ? '0 : req_pos_reg;

    // Cell chain: each cell looks at the word of the cell above it.
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [WORD_BITS-1:0] nbr;

        if (i + 1 < CAPACITY) begin : g_mid
            assign nbr = cell_word[i+1];
        end else begin : g_last
            assign nbr = '0;
        end

        assign cell_ctrl[i].load    = do_append && (CW'(i) == held_count_reg);
        assign cell_ctrl[i].shift   = do_remove && (i + 1 < CAPACITY) &&
                                      (CMPW'(i) >= CMPW'(rm_pos));
        assign cell_ctrl[i].compare = exec;

        olst_cell #(
            .WORD_BITS (WORD_BITS)
        ) u_cell (
            .aclk      (aclk),
            .ctrl      (cell_ctrl[i]),
            .nbr_word  (nbr),
            .load_word (req_word_reg),
            .cmp_word  (req_word_reg),
            .word      (cell_word[i]),
            .match     (cell_match[i])
        );

        // Only held positions may report a match.
        assign hit_vec[i] = cell_match[i] && (CW'(i) < held_count_reg);
    end

    olst_first_match #(
        .N (CAPACITY)
    ) u_first_match (
        .hits  (hit_vec),
        .found (hit_found),
        .index (hit_index)
    );

    always_comb begin
        rd_word = '0;
        for (int i = 0; i < RD_CELLS; i++) begin
            if (req_pos_reg == POS_W'(i)) begin
                rd_word = cell_word[i];
            end
        end
    end

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next       = state_reg;
        held_count_next  = held_count_reg;
        pend_status_next = pend_status_reg;
        pend_word_next   = pend_word_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_status_next    = m_status_reg;
        m_word_next      = m_word_reg;
        m_fpos_next      = m_fpos_reg;
        m_count_next     = m_count_reg;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                pend_status_next = STAT_MISS;
                pend_word_next   = '0;
                case (req_mode_reg)
                    MODE_APPEND: begin
                        if (full) begin
                            pend_status_next = STAT_FULL;
                        end else begin
                            pend_status_next = STAT_OK;
                            held_count_next  = held_count_reg + 1'b1;
                        end
                    end
                    MODE_POP: begin
                        if (nonempty) begin
                            pend_status_next = STAT_OK;
                            pend_word_next   = XWORD_W'(cell_word[0]);
                            held_count_next  = held_count_reg - 1'b1;
                        end
                    end
                    MODE_DROP, MODE_REMOVE: begin
                        if ((req_mode_reg == MODE_DROP) ? nonempty : pos_ok) begin
                            pend_status_next = STAT_OK;
                            held_count_next  = held_count_reg - 1'b1;
                        end
                    end
                    MODE_READ: begin
                        if (pos_ok) begin
                            pend_status_next = STAT_OK;
                            pend_word_next   = XWORD_W'(rd_word);
                        end
                    end
                    default: begin
                    end
                endcase
                state_next = S_FIND;
            end
            S_FIND: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_word_next   = pend_word_reg;
                    m_count_next  = COUNT_W'(held_count_reg);
                    m_status_next = pend_status_reg;
                    m_fpos_next   = '0;
                    if (req_mode_reg == MODE_SEARCH) begin
                        m_status_next = hit_found ? STAT_OK : STAT_MISS;
                        m_fpos_next   = hit_found ? POS_W'(hit_index) : '0;
                    end
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            held_count_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            held_count_reg <= held_count_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            req_mode_reg <= s_mode;
            req_word_reg <= WORD_BITS'(s_word_in);
            req_pos_reg  <= s_position;
        end
        pend_status_reg <= pend_status_next;
        pend_word_reg   <= pend_word_next;
        m_status_reg    <= m_status_next;
        m_word_reg      <= m_word_next;
        m_fpos_reg      <= m_fpos_next;
        m_count_reg     <= m_count_next;
    end

    assign s_ready          = (state_reg == S_IDLE);
    assign m_valid          = m_valid_reg;
    assign m_status         = m_status_reg;
    assign m_word_out       = m_word_reg;
    assign m_found_position = m_fpos_reg;
    assign m_entry_count    = m_count_reg;

    // The count can never pass the number of cells.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        CMPW'(held_count_reg) <= CMPW'(CAPACITY))
        else $error("held count exceeds capacity");

    // An accepted beat always moves straight into the execute step.
    a_accept_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == S_EXEC))
        else $error("accepted request did not execute");

    // The count only changes in the execute step.
    a_count_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_EXEC) |=> $stable(held_count_reg))
        else $error("held count changed outside execute");

    // Leaving the final step always presents a result beat.
    a_result_out: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == S_FIND) && out_free) |=> m_valid)
        else $error("result beat missing after final step");

endmodule

// ===== design/olst_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olst_cell: one storage cell of the list chain
// Holds one word, takes either its upper neighbour's word or a new word,
// and registers whether its word equals the search word.
// ----------------------------------------------------------------------------
module olst_cell
    import olst_pkg::*;
#(
    parameter int WORD_BITS = DEF_WORD_BITS
) (
    input  logic                 aclk,
    input  olst_cell_ctrl_t      ctrl,
    input  logic [WORD_BITS-1:0] nbr_word,
    input  logic [WORD_BITS-1:0] load_word,
    input  logic [WORD_BITS-1:0] cmp_word,
    output logic [WORD_BITS-1:0] word,
    output logic                 match
);

    logic [WORD_BITS-1:0] word_reg;
    logic [WORD_BITS-1:0] word_next;
    logic                 match_reg;
    logic                 match_next;

    always_comb begin
        word_next  = word_reg;
        match_next = match_reg;
        if (ctrl.load) begin
            word_next = load_word;
        end else if (ctrl.shift) begin
            word_next = nbr_word;
        end
        if (ctrl.compare) begin
            match_next = (word_reg == cmp_word);
        end
    end

    always_ff @(posedge aclk) begin
        word_reg  <= word_next;
        match_reg <= match_next;
    end

    assign word  = word_reg;
    assign match = match_reg;

endmodule

// ===== design/olst_first_match.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olst_first_match: priority encoder over the cell match flags
// Reports whether any flag is set and the lowest position that is set.
// ----------------------------------------------------------------------------
module olst_first_match
    import olst_pkg::*;
#(
    parameter int N = DEF_CAPACITY
) (
    input  logic [N-1:0]         hits,
    output logic                 found,
    output logic [$clog2(N)-1:0] index
);

    localparam int IW = $clog2(N);

    always_comb begin
        index = '0;
        for (int i = N - 1; i >= 0; i--) begin
            if (hits[i]) begin
                index = IW'(i);
            end
        end
        found = |hits;
    end

endmodule

// ===== dv/ordered_list_store_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_list_store_test: self-checking bench for the ordered list store
// A table of directed requests covers the empty list, the full list, the
// field extremes and the unused modes. Random requests follow in three idling
// patterns. Each result beat is checked against its row's typed result or a behavioural list copy.
// ----------------------------------------------------------------------------
module ordered_list_store_test;
    import olst_pkg::*;

    localparam int LIST_CAP     = DEF_CAPACITY;
    localparam int PHASE_ITEMS  = 560;
    localparam int BIAS_SPAN    = 64;
    localparam int TAIL_CYCLES  = 20;

    // Modes that the block does not implement.
    localparam logic [MODE_W-1:0] MODE_SPARE_A = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE_B = 3'd7;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [XWORD_W-1:0] word;
        logic [POS_W-1:0]   fpos;
        logic [COUNT_W-1:0] count;
    } list_result_t;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [XWORD_W-1:0] word;
        logic [POS_W-1:0]   pos;
        logic [4:0]         reps;
        logic               fixed;
        list_result_t       result;
    } stim_row_t;

    localparam int N_ROWS = 25;

    // Rows with fixed set carry their expected result; the rest use the predictor.
    stim_row_t directed_rows [N_ROWS] = '{
        '{MODE_POP,     32'h0000_0000, 4'd0,  5'd1,  1'b1, '{STAT_MISS, 32'h0, 4'd0, 5'd0}},
        '{MODE_DROP,    32'h0000_0000, 4'd0,  5'd1,  1'b1, '{STAT_MISS, 32'h0, 4'd0, 5'd0}},
        '{MODE_REMOVE,  32'hffff_ffff, 4'd0,  5'd1,  1'b1, '{STAT_MISS, 32'h0, 4'd0, 5'd0}},
        '{MODE_SEARCH,  32'h0000_0000, 4'd0,  5'd1,  1'b1, '{STAT_MISS, 32'h0, 4'd0, 5'd0}},
        '{MODE_READ,    32'h0000_0000, 4'd15, 5'd1,  1'b1, '{STAT_MISS, 32'h0, 4'd0, 5'd0}},
        '{MODE_SPARE_A, 32'h1234_5678, 4'd3,  5'd1,  1'b1, '{STAT_MISS, 32'h0, 4'd0, 5'd0}},
        '{MODE_SPARE_B, 32'hffff_ffff, 4'd15, 5'd1,  1'b1, '{STAT_MISS, 32'h0, 4'd0, 5'd0}},
        '{MODE_APPEND,  32'h0000_0000, 4'd15, 5'd1,  1'b1, '{STAT_OK, 32'h0, 4'd0, 5'd1}},
        '{MODE_APPEND,  32'hffff_ffff, 4'd0,  5'd1,  1'b1, '{STAT_OK, 32'h0, 4'd0, 5'd2}},
        '{MODE_READ,    32'h0000_0000, 4'd1,  5'd1,  1'b1,
            '{STAT_OK, 32'hffff_ffff, 4'd0, 5'd2}},
        '{MODE_SEARCH,  32'hffff_ffff, 4'd0,  5'd1,  1'b1, '{STAT_OK, 32'h0, 4'd1, 5'd2}},
        '{MODE_READ,    32'h0000_0000, 4'd2,  5'd1,  1'b1, '{STAT_MISS, 32'h0, 4'd0, 5'd2}},
        '{MODE_REMOVE,  32'h0000_0000, 4'd2,  5'd1,  1'b1, '{STAT_MISS, 32'h0, 4'd0, 5'd2}},
        '{MODE_APPEND,  32'ha5a5_a5a5, 4'd0,  5'd14, 1'b0, '0},
        '{MODE_APPEND,  32'h5a5a_5a5a, 4'd0,  5'd1,  1'b1, '{STAT_FULL, 32'h0, 4'd0, 5'd16}},
        '{MODE_SEARCH,  32'h5a5a_5a5a, 4'd0,  5'd1,  1'b1, '{STAT_MISS, 32'h0, 4'd0, 5'd16}},
        '{MODE_SEARCH,  32'ha5a5_a5a5, 4'd0,  5'd1,  1'b1, '{STAT_OK, 32'h0, 4'd2, 5'd16}},
        '{MODE_READ,    32'h0000_0000, 4'd15, 5'd1,  1'b1,
            '{STAT_OK, 32'ha5a5_a5a5, 4'd0, 5'd16}},
        '{MODE_REMOVE,  32'h0000_0000, 4'd15, 5'd1,  1'b0, '0},
        '{MODE_REMOVE,  32'h0000_0000, 4'd0,  5'd1,  1'b0, '0},
        '{MODE_POP,     32'h0000_0000, 4'd0,  5'd1,  1'b1,
            '{STAT_OK, 32'hffff_ffff, 4'd0, 5'd13}},
        '{MODE_APPEND,  32'h0000_0001, 4'd0,  5'd1,  1'b0, '0},
        '{MODE_DROP,    32'h0000_0000, 4'd0,  5'd1,  1'b0, '0},
        '{MODE_READ,    32'h0000_0000, 4'd12, 5'd1,  1'b0, '0},
        '{MODE_REMOVE,  32'h0000_0000, 4'd6,  5'd1,  1'b0, '0}
    };

    logic               aclk;
    logic               aresetn    = 1'b0;
    logic               s_valid    = 1'b0;
    logic               s_ready;
    logic [MODE_W-1:0]  s_mode     = MODE_APPEND;
    logic [XWORD_W-1:0] s_word_in  = '0;
    logic [POS_W-1:0]   s_position = '0;
    logic               m_valid;
    logic               m_ready    = 1'b0;
    logic [STAT_W-1:0]  m_status;
    logic [XWORD_W-1:0] m_word_out;
    logic [POS_W-1:0]   m_found_position;
    logic [COUNT_W-1:0] m_entry_count;

    // Behavioural copy of the list.
    logic [XWORD_W-1:0] list_words [LIST_CAP];
    logic [COUNT_W-1:0] list_len = '0;

    list_result_t pending_results [$];
    int mismatch_count = 0;
    int tx_idle_pct    = 32;
    int rx_idle_pct    = 60;
    int fill_bias      = 40;

    ordered_list_store uut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_mode           (s_mode),
        .s_word_in        (s_word_in),
        .s_position       (s_position),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_word_out       (m_word_out),
        .m_found_position (m_found_position),
        .m_entry_count    (m_entry_count)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5000000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic void close_gap(input int idx);
        int i;
        for (i = idx; i + 1 < list_len; i++) begin
            list_words[i] = list_words[i + 1];
        end
        list_len--;
    endfunction

    function automatic list_result_t apply_request(input logic [MODE_W-1:0] mode,
                                                   input logic [XWORD_W-1:0] word,
                                                   input logic [POS_W-1:0] pos);
        list_result_t res;
        int idx;
        bit hit;
        res = '0;
        res.status = STAT_MISS;
        hit = 1'b0;
        case (mode)
            MODE_APPEND: begin
                if (list_len >= LIST_CAP) begin
                    res.status = STAT_FULL;
                end else begin
                    list_words[list_len[POS_W-1:0]] = word;
                    list_len++;
                    res.status = STAT_OK;
                end
            end
            MODE_POP: begin
                if (list_len != 0) begin
                    res.word = list_words[0];
                    close_gap(0);
                    res.status = STAT_OK;
                end
            end
            MODE_DROP: begin
                if (list_len != 0) begin
                    list_len--;
                    res.status = STAT_OK;
                end
            end
            MODE_REMOVE: begin
                if (pos < list_len) begin
                    close_gap(int'(pos));
                    res.status = STAT_OK;
                end
            end
            MODE_SEARCH: begin
                // Only held positions take part, and the first match wins.
                for (idx = 0; idx < list_len; idx++) begin
                    if (!hit && list_words[idx] == word) begin
                        hit = 1'b1;
                        res.status = STAT_OK;
                        res.fpos = idx[POS_W-1:0];
                    end
                end
            end
            MODE_READ: begin
                if (pos < list_len) begin
                    res.word = list_words[pos];
                    res.status = STAT_OK;
                end
            end
            default: begin
            end
        endcase
        res.count = list_len;
        return res;
    endfunction

    task automatic issue_request(input logic [MODE_W-1:0] mode,
                                 input logic [XWORD_W-1:0] word,
                                 input logic [POS_W-1:0] pos,
                                 input logic fixed,
                                 input list_result_t typed);
        list_result_t predicted;
        if ($urandom_range(0, 99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < tx_idle_pct);
        end
        s_valid    <= 1'b1;
        s_mode     <= mode;
        s_word_in  <= word;
        s_position <= pos;
        do @(posedge aclk); while (!s_ready);
        predicted = apply_request(mode, word, pos);
        pending_results.push_back(fixed ? typed : predicted);
    endtask

    task automatic random_request();
        logic [MODE_W-1:0]  mode;
        logic [XWORD_W-1:0] word;
        logic [POS_W-1:0]   pos;
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < fill_bias) begin
            mode = MODE_APPEND;
        end else begin
            roll = $urandom_range(0, 99);
            if (roll < 15)      mode = MODE_POP;
            else if (roll < 30) mode = MODE_DROP;
            else if (roll < 55) mode = MODE_REMOVE;
            else if (roll < 75) mode = MODE_SEARCH;
            else if (roll < 95) mode = MODE_READ;
            else                mode = roll[0] ? MODE_SPARE_A : MODE_SPARE_B;
        end
        // Small values give duplicates, so the search has to pick the first match.
        if (mode == MODE_SEARCH && list_len != 0 && $urandom_range(0, 3) != 0) begin
            word = list_words[POS_W'($urandom_range(0, list_len - 1))];
        end else if ($urandom_range(0, 3) == 0) begin
            word = $urandom_range(0, 7);
        end else begin
            word = $urandom;
        end
        if (list_len != 0 && $urandom_range(0, 4) != 0) begin
            pos = POS_W'($urandom_range(0, list_len - 1));
        end else begin
            pos = POS_W'($urandom_range(0, 15));
        end
        issue_request(mode, word, pos, 1'b0, '0);
    endtask

    // Hold the request channel quiet until every outstanding result has arrived.
    task automatic settle_list();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_results.size() != 0);
    endtask

    task automatic report_field(input string name, input logic [XWORD_W-1:0] want,
                                input logic [XWORD_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    task automatic check_result();
        list_result_t want;
        if (pending_results.size() == 0) begin
            $display("%0t: result beat with nothing expected, status %0d word %h pos %0d count %0d",
                     $time, m_status, m_word_out, m_found_position, m_entry_count);
            mismatch_count++;
        end else begin
            want = pending_results.pop_front();
            report_field("status", XWORD_W'(want.status), XWORD_W'(m_status));
            report_field("word_out", want.word, m_word_out);
            report_field("found_position", XWORD_W'(want.fpos), XWORD_W'(m_found_position));
            report_field("entry_count", XWORD_W'(want.count), XWORD_W'(m_entry_count));
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                check_result();
            end
            m_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    initial begin
        int row;
        int rep;
        int phase;
        int item;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (row = 0; row < N_ROWS; row++) begin
            for (rep = 0; rep < directed_rows[row].reps; rep++) begin
                issue_request(directed_rows[row].mode, directed_rows[row].word,
                              directed_rows[row].pos, directed_rows[row].fixed,
                              directed_rows[row].result);
            end
        end

        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    tx_idle_pct = 32;
                    rx_idle_pct = 60;
                end
                1: begin
                    tx_idle_pct = 60;
                    rx_idle_pct = 32;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            for (item = 0; item < PHASE_ITEMS; item++) begin
                // A fresh append weight now and then lets the list swing between
                // empty and full.
                if (item % BIAS_SPAN == 0) begin
                    fill_bias = $urandom_range(15, 65);
                end
                random_request();
            end
            settle_list();
        end

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
